[rtl/timestamped_signal_freshness_store_defines.svh]
// Assertion macros used by the checker file of the freshness store.
// No dependencies; take in with `include by bare file name.
`ifndef TIMESTAMPED_SIGNAL_FRESHNESS_STORE_DEFINES_SVH
`define TIMESTAMPED_SIGNAL_FRESHNESS_STORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is low.
`define TSFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define TSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TSFS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tsfs_pkg.sv]
// Types, constants and command codes of the timestamped signal freshness store.
// No dependencies.
`default_nettype none

package tsfs_pkg;

    localparam int SIGNAL_COUNT_DEF = 32;
    localparam int CMD_W     = 3;
    localparam int ID_W      = 8;
    localparam int DATA_W    = 32;
    localparam int FLAG_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] SKEW_RESET = 32'd2000;
    localparam logic [DATA_W-1:0] AGE_NONE   = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SKEW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE        = 3'd0,
        CMD_READ          = 3'd1,
        CMD_MARK_INVALID  = 3'd2,
        CMD_SET_STALE     = 3'd3,
        CMD_SET_ALL_STALE = 3'd4
    } t_cmd;

    // One input word as held in the pipeline.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   signal_id;
        logic [DATA_W-1:0] value_bits;
        logic [DATA_W-1:0] now_ms;
        logic [FLAG_W-1:0] sample_flags;
        logic [DATA_W-1:0] amount_ms;
    } t_item;

    // One slot of the signal table.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] stamp;
        logic [FLAG_W-1:0] flags;
        logic [DATA_W-1:0] hold;
        logic [DATA_W-1:0] limit;
    } t_entry;

    // One result word.
    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic              valid_res;
        logic [DATA_W-1:0] age_out_ms;
        logic [FLAG_W-1:0] flags_out;
        logic              invalid_mark;
        logic              stale_mark;
    } t_result;

endpackage

`default_nettype wire

[rtl/tsfs_if.sv]
// Handshake channels of the freshness store: command words, result words, config writes.
// Depends on tsfs_pkg for field widths.
`default_nettype none

interface tsfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [tsfs_pkg::CMD_W-1:0]    command;
    logic [tsfs_pkg::ID_W-1:0]     signal_id;
    logic [tsfs_pkg::DATA_W-1:0]   value_bits;
    logic [tsfs_pkg::DATA_W-1:0]   now_ms;
    logic [tsfs_pkg::FLAG_W-1:0]   sample_flags;
    logic [tsfs_pkg::DATA_W-1:0]   amount_ms;

    modport source (output valid, command, signal_id, value_bits, now_ms, sample_flags,
                    amount_ms, input ready);
    modport sink   (input valid, command, signal_id, value_bits, now_ms, sample_flags,
                    amount_ms, output ready);
endinterface

interface tsfs_res_if;
    logic                          valid;
    logic                          ready;
    logic [tsfs_pkg::DATA_W-1:0]   value_out;
    logic                          valid_res;
    logic [tsfs_pkg::DATA_W-1:0]   age_out_ms;
    logic [tsfs_pkg::FLAG_W-1:0]   flags_out;
    logic                          invalid_mark;
    logic                          stale_mark;

    modport source (output valid, value_out, valid_res, age_out_ms, flags_out, invalid_mark,
                    stale_mark, input ready);
    modport sink   (input valid, value_out, valid_res, age_out_ms, flags_out, invalid_mark,
                    stale_mark, output ready);
endinterface

interface tsfs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tsfs_pkg::CFG_IDX_W-1:0] index;
    logic [tsfs_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tsfs_judge.sv]
// Freshness verdict for one read: age with wrap and skew, hold, expiry and stale checks.
// Depends on tsfs_pkg for the entry and result types.
`default_nettype none

module tsfs_judge (
    input  tsfs_pkg::t_entry              i_entry,
    input  logic [tsfs_pkg::DATA_W-1:0]   i_now_ms,
    input  logic [tsfs_pkg::DATA_W-1:0]   i_skew_ms,
    input  logic [tsfs_pkg::DATA_W-1:0]   i_expire_limit,
    output tsfs_pkg::t_result             o_res
);

    logic                          written;
    logic                          future;
    logic                          held;
    logic                          expired;
    logic                          over_limit;
    logic [tsfs_pkg::DATA_W-1:0]   diff;
    logic [tsfs_pkg::DATA_W-1:0]   lead;
    logic [tsfs_pkg::DATA_W-1:0]   age;

    always_comb begin
        written = (i_entry.stamp != '0);
        diff    = i_now_ms - i_entry.stamp;
        lead    = i_entry.stamp - i_now_ms;
        future  = (i_now_ms < i_entry.stamp);

        if (!written) begin
            age = tsfs_pkg::AGE_NONE;
        end else if (future && (lead <= i_skew_ms)) begin
            age = '0;
        end else begin
            age = diff;
        end

        // plain unsigned deadline compare, no wrap handling
        held       = (i_now_ms < i_entry.hold);
        expired    = (i_expire_limit != '0) && (age > i_expire_limit);
        over_limit = (age > i_entry.limit);

        o_res.value_out    = i_entry.value;
        o_res.age_out_ms   = age;
        o_res.flags_out    = i_entry.flags;
        o_res.valid_res    = written && !held && !expired;
        o_res.invalid_mark = held;
        o_res.stale_mark   = !held && written && (expired || over_limit);
    end

endmodule

`default_nettype wire

[rtl/timestamped_signal_freshness_store.sv]
// Top level of the timestamped signal freshness store: slot memory, pipeline, config.
// Depends on tsfs_pkg, tsfs_if (channels) and tsfs_judge.
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+------------------------------------------
//  i_cfg    | in  | valid/ready      | index, data (skew tolerance, expire limit)
//  i_in     | in  | valid/ready      | command, id, value, now, flags, amount
//  o_out    | out | valid/ready      | value, valid, age, flags, invalid, stale
//
// One word per cycle sustained while results are taken; a taken command sits in stage 1
// and its result is registered in the result register, from which it leaves on o_out.ready.
// Slots sit in one memory read at accept and written back from stage 1; a
// forward register covers a command that reads the slot just written.
// Set-all loads a global limit and clears the per-slot override bits.
// Reset is synchronous and needs no clearing pass: per-slot valid bits gate the memory.
// A full result register that is not taken holds the pipeline; i_in.ready drops once
// stage 1 is also full.
`default_nettype none

module timestamped_signal_freshness_store #(
    parameter int SIGNAL_COUNT = tsfs_pkg::SIGNAL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsfs_cfg_if.sink    i_cfg,
    tsfs_in_if.sink     i_in,
    tsfs_res_if.source  o_out
);

    localparam int IDX_W = (SIGNAL_COUNT > 1) ? $clog2(SIGNAL_COUNT) : 1;
    localparam logic [tsfs_pkg::ID_W:0] COUNT_V = (tsfs_pkg::ID_W + 1)'(SIGNAL_COUNT);

    // config registers
    logic [tsfs_pkg::DATA_W-1:0] r_skew;
    logic [tsfs_pkg::DATA_W-1:0] r_expire;

    // slot memory and its per-slot valid bits
    tsfs_pkg::t_entry            r_mem [SIGNAL_COUNT];
    tsfs_pkg::t_entry            r_rdata;
    logic [SIGNAL_COUNT-1:0]     r_written;
    logic [SIGNAL_COUNT-1:0]     r_held;
    logic [SIGNAL_COUNT-1:0]     r_own;
    logic [tsfs_pkg::DATA_W-1:0] r_glob_limit;

    // write-back forward
    logic                        r_fwd_v;
    logic [IDX_W-1:0]            r_fwd_idx;
    tsfs_pkg::t_entry            r_fwd_data;

    // pipeline
    logic                        r_s1_v;
    tsfs_pkg::t_item             r_s1;
    logic                        r_out_v;
    tsfs_pkg::t_result           r_out;

    tsfs_pkg::t_item             in_item;
    tsfs_pkg::t_entry            src;
    tsfs_pkg::t_entry            view;
    tsfs_pkg::t_entry            n_wr_data;
    tsfs_pkg::t_result           judge_res;
    tsfs_pkg::t_result           n_out;
    logic                        n_wr_en;
    logic [IDX_W-1:0]            in_idx;
    logic [IDX_W-1:0]            s1_idx;
    logic                        in_range;
    logic                        accept;
    logic                        adv;
    logic                        fire;

    // ---------------- config port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skew   <= tsfs_pkg::SKEW_RESET;
            r_expire <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tsfs_pkg::CFG_SKEW:   r_skew   <= i_cfg.data;
                tsfs_pkg::CFG_EXPIRE: r_expire <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign adv        = !r_out_v || o_out.ready;
    assign i_in.ready = !r_s1_v || adv;
    assign accept     = i_in.valid && i_in.ready;
    assign fire       = r_s1_v && adv;

    always_comb begin
        in_item.command      = i_in.command;
        in_item.signal_id    = i_in.signal_id;
        in_item.value_bits   = i_in.value_bits;
        in_item.now_ms       = i_in.now_ms;
        in_item.sample_flags = i_in.sample_flags;
        in_item.amount_ms    = i_in.amount_ms;
    end

    assign in_idx   = i_in.signal_id[IDX_W-1:0];
    assign s1_idx   = r_s1.signal_id[IDX_W-1:0];
    assign in_range = ({1'b0, r_s1.signal_id} < COUNT_V);

    // ---------------- memory ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[s1_idx] <= n_wr_data;
        end
    end

    // ---------------- stage 1: read-modify-write ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= in_item;
        end
    end

    always_comb begin
        // take the last written slot over the stale memory word
        if (r_fwd_v && (r_fwd_idx == s1_idx)) begin
            src = r_fwd_data;
        end else begin
            src = r_rdata;
        end

        view.value = r_written[s1_idx] ? src.value : '0;
        view.stamp = r_written[s1_idx] ? src.stamp : '0;
        view.flags = r_written[s1_idx] ? src.flags : '0;
        view.hold  = r_held[s1_idx]    ? src.hold  : '0;
        view.limit = r_own[s1_idx]     ? src.limit : r_glob_limit;
    end

    tsfs_judge u_judge (
        .i_entry        (view),
        .i_now_ms       (r_s1.now_ms),
        .i_skew_ms      (r_skew),
        .i_expire_limit (r_expire),
        .o_res          (judge_res)
    );

    always_comb begin
        n_wr_data = src;
        n_wr_en   = 1'b0;
        n_out     = '0;
        case (r_s1.command)
            tsfs_pkg::CMD_UPDATE: begin
                n_wr_data.value = r_s1.value_bits;
                n_wr_data.stamp = r_s1.now_ms;
                n_wr_data.flags = r_s1.sample_flags;
                n_wr_en         = fire && in_range;
            end
            tsfs_pkg::CMD_READ: begin
                if (in_range) begin
                    n_out = judge_res;
                end
            end
            tsfs_pkg::CMD_MARK_INVALID: begin
                n_wr_data.hold = r_s1.now_ms + r_s1.amount_ms;
                n_wr_en        = fire && in_range;
            end
            tsfs_pkg::CMD_SET_STALE: begin
                n_wr_data.limit = r_s1.amount_ms;
                n_wr_en         = fire && in_range;
            end
            default: ;
        endcase
    end

    // per-slot valid bits and the global limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_held       <= '0;
            r_own        <= '0;
            r_glob_limit <= '0;
        end else if (fire) begin
            case (r_s1.command)
                tsfs_pkg::CMD_UPDATE: begin
                    if (in_range) begin
                        r_written[s1_idx] <= 1'b1;
                        r_held[s1_idx]    <= 1'b0;
                    end
                end
                tsfs_pkg::CMD_MARK_INVALID: begin
                    if (in_range) begin
                        r_held[s1_idx] <= 1'b1;
                    end
                end
                tsfs_pkg::CMD_SET_STALE: begin
                    if (in_range) begin
                        r_own[s1_idx] <= 1'b1;
                    end
                end
                tsfs_pkg::CMD_SET_ALL_STALE: begin
                    r_own        <= '0;
                    r_glob_limit <= r_s1.amount_ms;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (n_wr_en) begin
            r_fwd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_fwd_idx  <= s1_idx;
            r_fwd_data <= n_wr_data;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.value_out    = r_out.value_out;
    assign o_out.valid_res    = r_out.valid_res;
    assign o_out.age_out_ms   = r_out.age_out_ms;
    assign o_out.flags_out    = r_out.flags_out;
    assign o_out.invalid_mark = r_out.invalid_mark;
    assign o_out.stale_mark   = r_out.stale_mark;

endmodule

`default_nettype wire

[rtl/tsfs_checker.sv]
// Port-level checks of the freshness store, bound to the top level.
// Depends on timestamped_signal_freshness_store_defines.svh for the assertion macros.
`default_nettype none

`include "timestamped_signal_freshness_store_defines.svh"

module tsfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_value_out,
    input logic        i_valid_res,
    input logic        i_invalid_mark,
    input logic        i_stale_mark
);

    // an active hold never comes with a good reading
    `TSFS_ASSERT_IMPLY(a_hold_not_valid, i_clk, i_rst_n, i_out_valid && i_invalid_mark, !i_valid_res, "held slot reported valid")

    // a hold skips the stale check
    `TSFS_ASSERT_IMPLY(a_marks_excl, i_clk, i_rst_n, i_out_valid, !(i_invalid_mark && i_stale_mark), "invalid and stale both set")

    // result register comes out of reset empty
    `TSFS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "result valid right after reset")

    // a stalled result word holds
    `TSFS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_value_out), "stalled result changed")

endmodule

bind timestamped_signal_freshness_store tsfs_checker u_tsfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_value_out    (o_out.value_out),
    .i_valid_res    (o_out.valid_res),
    .i_invalid_mark (o_out.invalid_mark),
    .i_stale_mark   (o_out.stale_mark)
);

`default_nettype wire
